// ===== sv/mclsc_pkg.sv =====
// Shared types, codes and reset constants for the majority-clocked LFSR cipher.
package mclsc_pkg;

    localparam int TAP_W  = 5;
    localparam int POS_W  = 3;
    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_KEY   = 2'd1,
        OP_DATA  = 2'd2
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_TAP_A = 3'd0,
        REG_TAP_B = 3'd1,
        REG_TAP_C = 3'd2,
        REG_POS_A = 3'd3,
        REG_POS_B = 3'd4,
        REG_POS_C = 3'd5
    } reg_idx_t;

    localparam logic [TAP_W-1:0] TAP_A_RST = 5'd6;
    localparam logic [TAP_W-1:0] TAP_B_RST = 5'd12;
    localparam logic [TAP_W-1:0] TAP_C_RST = 5'd18;
    localparam logic [POS_W-1:0] POS_A_RST = 3'd2;
    localparam logic [POS_W-1:0] POS_B_RST = 3'd1;
    localparam logic [POS_W-1:0] POS_C_RST = 3'd3;

    typedef struct packed {
        logic [TAP_W-1:0] tap_a;
        logic [TAP_W-1:0] tap_b;
        logic [TAP_W-1:0] tap_c;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [POS_W-1:0] pos_c;
    } cfg_t;

    typedef struct packed {
        logic            fire;
        logic [OP_W-1:0] op;
        logic            bit_value;
    } item_t;

endpackage

// ===== sv/mclsc_cfg.sv =====
// APB configuration register file for tap masks and clocking positions.
module mclsc_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mclsc_pkg::ADDR_W-1:0] paddr,
    input  logic [mclsc_pkg::DATA_W-1:0] pwdata,
    output logic [mclsc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output mclsc_pkg::cfg_t              cfg
);

    mclsc_pkg::cfg_t cfg_reg;
    mclsc_pkg::cfg_t cfg_next;
    logic [mclsc_pkg::IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[mclsc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                mclsc_pkg::REG_TAP_A: cfg_next.tap_a = pwdata[mclsc_pkg::TAP_W-1:0];
                mclsc_pkg::REG_TAP_B: cfg_next.tap_b = pwdata[mclsc_pkg::TAP_W-1:0];
                mclsc_pkg::REG_TAP_C: cfg_next.tap_c = pwdata[mclsc_pkg::TAP_W-1:0];
                mclsc_pkg::REG_POS_A: cfg_next.pos_a = pwdata[mclsc_pkg::POS_W-1:0];
                mclsc_pkg::REG_POS_B: cfg_next.pos_b = pwdata[mclsc_pkg::POS_W-1:0];
                mclsc_pkg::REG_POS_C: cfg_next.pos_c = pwdata[mclsc_pkg::POS_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mclsc_pkg::REG_TAP_A: prdata = mclsc_pkg::DATA_W'(cfg_reg.tap_a);
            mclsc_pkg::REG_TAP_B: prdata = mclsc_pkg::DATA_W'(cfg_reg.tap_b);
            mclsc_pkg::REG_TAP_C: prdata = mclsc_pkg::DATA_W'(cfg_reg.tap_c);
            mclsc_pkg::REG_POS_A: prdata = mclsc_pkg::DATA_W'(cfg_reg.pos_a);
            mclsc_pkg::REG_POS_B: prdata = mclsc_pkg::DATA_W'(cfg_reg.pos_b);
            mclsc_pkg::REG_POS_C: prdata = mclsc_pkg::DATA_W'(cfg_reg.pos_c);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_a <= mclsc_pkg::TAP_A_RST;
            cfg_reg.tap_b <= mclsc_pkg::TAP_B_RST;
            cfg_reg.tap_c <= mclsc_pkg::TAP_C_RST;
            cfg_reg.pos_a <= mclsc_pkg::POS_A_RST;
            cfg_reg.pos_b <= mclsc_pkg::POS_B_RST;
            cfg_reg.pos_c <= mclsc_pkg::POS_C_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/mclsc_core.sv =====
// Three LFSRs with key loading, majority clocking and keystream output.
module mclsc_core
#(
    parameter int REG_LEN = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mclsc_pkg::cfg_t  cfg,
    input  mclsc_pkg::item_t item,
    output logic             ks
);

    localparam int KEY_W = $clog2(REG_LEN);
    localparam int EXT_W = (REG_LEN > 8) ? REG_LEN : 8;

    logic [REG_LEN-1:0] ra_reg, rb_reg, rc_reg;
    logic [REG_LEN-1:0] ra_next, rb_next, rc_next;
    logic [KEY_W-1:0]   kidx_reg, kidx_next;

    logic [EXT_W-1:0]   ra_ext, rb_ext, rc_ext;
    logic               ca, cb, cc, maj;
    logic               fa, fb, fc;
    logic [REG_LEN-1:0] sa, sb, sc;
    logic [REG_LEN-1:0] key_mask;

    assign ra_ext = EXT_W'(ra_reg);
    assign rb_ext = EXT_W'(rb_reg);
    assign rc_ext = EXT_W'(rc_reg);

    assign ca  = ra_ext[cfg.pos_a];
    assign cb  = rb_ext[cfg.pos_b];
    assign cc  = rc_ext[cfg.pos_c];
    assign maj = (ca & cb) | (ca & cc) | (cb & cc);

    assign fa = ^(ra_ext & EXT_W'(cfg.tap_a));
    assign fb = ^(rb_ext & EXT_W'(cfg.tap_b));
    assign fc = ^(rc_ext & EXT_W'(cfg.tap_c));

    assign sa = (ca == maj) ? {ra_reg[REG_LEN-2:0], fa} : ra_reg;
    assign sb = (cb == maj) ? {rb_reg[REG_LEN-2:0], fb} : rb_reg;
    assign sc = (cc == maj) ? {rc_reg[REG_LEN-2:0], fc} : rc_reg;

    assign ks = sa[REG_LEN-1] ^ sb[REG_LEN-1] ^ sc[REG_LEN-1];

    assign key_mask = REG_LEN'(item.bit_value) << kidx_reg;

    always_comb
    begin
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        rc_next   = rc_reg;
        kidx_next = kidx_reg;
        if (item.fire)
        begin
            case (item.op)
                mclsc_pkg::OP_START:
                begin
                    ra_next   = '0;
                    rb_next   = '0;
                    rc_next   = '0;
                    kidx_next = '0;
                end
                mclsc_pkg::OP_KEY:
                begin
                    ra_next   = ra_reg ^ key_mask;
                    rb_next   = rb_reg ^ key_mask;
                    rc_next   = rc_reg ^ key_mask;
                    kidx_next = (kidx_reg == KEY_W'(REG_LEN - 1)) ? '0 : kidx_reg + 1'b1;
                end
                mclsc_pkg::OP_DATA:
                begin
                    ra_next = sa;
                    rb_next = sb;
                    rc_next = sc;
                end
                default:
                begin
                    ra_next = ra_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_reg   <= '0;
            rb_reg   <= '0;
            rc_reg   <= '0;
            kidx_reg <= '0;
        end
        else
        begin
            ra_reg   <= ra_next;
            rb_reg   <= rb_next;
            rc_reg   <= rc_next;
            kidx_reg <= kidx_next;
        end
    end

endmodule

// ===== sv/majority_clocked_lfsr_stream_cipher_unit.sv =====
// Top level: item register, cipher core, result register and APB configuration.
// One transaction enters per cycle while item_stall is low. An accepted item waits
// in the item register until it advances; the advance updates the three LFSRs for
// start, key and data items and, for a data bit, loads the result register, which
// raises result_valid. The result is taken at an edge where result_stall is low.
// Start, key-bit and unused operations give no result. The item side stalls only
// while a data bit in the item register faces a full, stalled result register.
// Configuration is to be written over APB only while the block is idle; the block does not enforce this.
module majority_clocked_lfsr_stream_cipher_unit
#(
    parameter int REG_LEN = 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mclsc_pkg::ADDR_W-1:0] paddr,
    input  logic [mclsc_pkg::DATA_W-1:0] pwdata,
    output logic [mclsc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [mclsc_pkg::OP_W-1:0]   operation,
    input  logic                         bit_value,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         out_bit,
    output logic                         keystream_bit
);

    mclsc_pkg::cfg_t  cfg;
    mclsc_pkg::item_t item;

    logic                       in_vld_reg, in_vld_next;
    logic [mclsc_pkg::OP_W-1:0] op_reg;
    logic                       bit_reg;
    logic                       out_vld_reg, out_vld_next;
    logic                       out_bit_reg, ks_reg;
    logic                       ks;
    logic                       is_data, adv, accept;

    mclsc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mclsc_core #(.REG_LEN(REG_LEN)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item),
        .ks    (ks)
    );

    assign is_data    = (op_reg == mclsc_pkg::OP_DATA);
    assign adv        = in_vld_reg && (!is_data || !out_vld_reg || !result_stall);
    assign item_stall = in_vld_reg && !adv;
    assign accept     = item_valid && !item_stall;

    assign item.fire      = adv;
    assign item.op        = op_reg;
    assign item.bit_value = bit_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (adv && is_data)
        begin
            out_vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            bit_reg <= bit_value;
        end
        if (adv && is_data)
        begin
            out_bit_reg <= bit_reg ^ ks;
            ks_reg      <= ks;
        end
    end

    assign result_valid  = out_vld_reg;
    assign out_bit       = out_bit_reg;
    assign keystream_bit = ks_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_vld_reg && is_data && out_vld_reg))
        else $error("item side stalled without a blocked data bit");

    a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && is_data) |=> (result_valid && (out_bit ^ keystream_bit) == $past(bit_reg)))
        else $error("data bit did not produce a matching result");

    a_nodata_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !is_data && result_valid && result_stall) |=>
        (result_valid && $stable(keystream_bit)))
        else $error("non-data item disturbed a held result");

endmodule
